// ===== sv/biquad_iir_sample_filter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Biquad IIR sample filter: assertion macros
// Shared property forms used by the checker of the filter unit.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_SAMPLE_FILTER_UNIT_DEFINES_SVH
`define BIQUAD_IIR_SAMPLE_FILTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR sample filter: package
// Widths, constants, register indexes and shared types of the filter unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package biq_pkg;

    localparam int DEF_SAMPLE_BITS     = 12;
    localparam int DEF_COEFF_FRAC_BITS = 28;

    localparam int COEFF_W       = 32;
    localparam int HIST_W        = 36;
    localparam int HIST_FRAC     = 16;
    localparam int OFFSET_COUNTS = 1862;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0        = 3'd0,
        CFG_B1        = 3'd1,
        CFG_B2        = 3'd2,
        CFG_A1        = 3'd3,
        CFG_A2        = 3'd4,
        CFG_OFFSET_EN = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        ACT_FILTER = 1'b0,
        ACT_CLEAR  = 1'b1
    } t_action;

    typedef struct packed {
        logic signed [COEFF_W-1:0] b0;
        logic signed [COEFF_W-1:0] b1;
        logic signed [COEFF_W-1:0] b2;
        logic signed [COEFF_W-1:0] a1;
        logic signed [COEFF_W-1:0] a2;
    } t_coeffs;

endpackage

// ===== sv/biquad_iir_sample_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR sample filter unit
// A second-order direct-form-I IIR filter that turns a stream of converter
// readings into DAC codes. It accepts one word in every clock cycle while
// the output side does not stall: the word is caught in the input register
// at the accepting edge, and the complete multiply-accumulate step then
// runs combinationally from that register and ends in the result register.
// The sustained rate of
// one word per cycle rests on that combinational step, since the next
// sample needs the output just computed. A word whose tuser flag is set clears
// all filter history and gives no result; its tdata is ignored. Coefficients
// are signed with COEFF_FRAC_BITS fraction bits, and b0 resets to 1.0, so the
// block passes samples straight through until it is programmed. The output
// history holds 16 fraction bits and saturates at 36 bits; the offset of 1862
// counts, when enabled, is added before the clamp to the code range.
// The user must write registers only while no word is in flight; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_iir_sample_filter_unit #(
    parameter int  SAMPLE_BITS     = biq_pkg::DEF_SAMPLE_BITS,
    parameter int  COEFF_FRAC_BITS = biq_pkg::DEF_COEFF_FRAC_BITS,
    localparam int TDATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [TDATA_W-1:0]                s_axis_tdata,  // sample, zero padding
    input  logic                              s_axis_tuser,  // action (1 clears history)

    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [TDATA_W-1:0]                m_axis_tdata,  // dac_code, zero padding

    // Register write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [biq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [biq_pkg::COEFF_W-1:0]       i_cfg_data
);

    localparam logic signed [biq_pkg::COEFF_W-1:0] COEFF_ONE =
        biq_pkg::COEFF_W'(1) << COEFF_FRAC_BITS;

    // Configuration registers.
    biq_pkg::t_coeffs                    r_coeffs;
    logic                                r_offset_en;

    // Input stage.
    logic                                r_in_valid;
    biq_pkg::t_action                    r_in_action;
    logic [SAMPLE_BITS-1:0]              r_in_sample;

    // Filter history.
    logic [SAMPLE_BITS-1:0]              r_x1, r_x2;
    logic signed [biq_pkg::HIST_W-1:0]   r_y1, r_y2;

    // Result stage.
    logic                                r_out_valid;
    logic [SAMPLE_BITS-1:0]              r_out_code;

    logic                                w_advance;
    logic                                w_in_accept;
    logic signed [biq_pkg::HIST_W-1:0]   n_y;
    logic [SAMPLE_BITS-1:0]              n_code;

    // The word in the input stage moves on when it is a clear (it needs no
    // result slot) or when the result register is free or being emptied.
    assign w_advance     = r_in_valid && ((r_in_action == biq_pkg::ACT_CLEAR) ||
                                          !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_code);

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs.b0 <= COEFF_ONE;
            r_coeffs.b1 <= '0;
            r_coeffs.b2 <= '0;
            r_coeffs.a1 <= '0;
            r_coeffs.a2 <= '0;
            r_offset_en <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (biq_pkg::t_cfg_idx'(i_cfg_index))
                biq_pkg::CFG_B0:        r_coeffs.b0 <= signed'(i_cfg_data);
                biq_pkg::CFG_B1:        r_coeffs.b1 <= signed'(i_cfg_data);
                biq_pkg::CFG_B2:        r_coeffs.b2 <= signed'(i_cfg_data);
                biq_pkg::CFG_A1:        r_coeffs.a1 <= signed'(i_cfg_data);
                biq_pkg::CFG_A2:        r_coeffs.a2 <= signed'(i_cfg_data);
                biq_pkg::CFG_OFFSET_EN: r_offset_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Control and history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end

            if (w_advance && (r_in_action == biq_pkg::ACT_CLEAR)) begin
                r_x1 <= '0;
                r_x2 <= '0;
                r_y1 <= '0;
                r_y2 <= '0;
            end else if (w_advance) begin
                r_x1 <= r_in_sample;
                r_x2 <= r_x1;
                r_y1 <= n_y;
                r_y2 <= r_y1;
            end

            if (w_advance && (r_in_action == biq_pkg::ACT_FILTER)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_action <= biq_pkg::t_action'(s_axis_tuser);
            r_in_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (w_advance && (r_in_action == biq_pkg::ACT_FILTER)) begin
            r_out_code <= n_code;
        end
    end

    biq_core #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_core (
        .i_coeffs    (r_coeffs),
        .i_offset_en (r_offset_en),
        .i_x0        (r_in_sample),
        .i_x1        (r_x1),
        .i_x2        (r_x2),
        .i_y1        (r_y1),
        .i_y2        (r_y2),
        .o_y         (n_y),
        .o_code      (n_code)
    );

endmodule

// ===== sv/biq_core.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR sample filter: arithmetic core
// One direct-form-I step: multiply-accumulate, history saturation, offset,
// clamp to the DAC code range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biq_core #(
    parameter int SAMPLE_BITS     = biq_pkg::DEF_SAMPLE_BITS,
    parameter int COEFF_FRAC_BITS = biq_pkg::DEF_COEFF_FRAC_BITS
) (
    input  biq_pkg::t_coeffs                   i_coeffs,
    input  logic                               i_offset_en,
    input  logic [SAMPLE_BITS-1:0]             i_x0,
    input  logic [SAMPLE_BITS-1:0]             i_x1,
    input  logic [SAMPLE_BITS-1:0]             i_x2,
    input  logic signed [biq_pkg::HIST_W-1:0]  i_y1,
    input  logic signed [biq_pkg::HIST_W-1:0]  i_y2,
    output logic signed [biq_pkg::HIST_W-1:0]  o_y,
    output logic [SAMPLE_BITS-1:0]             o_code
);

    localparam int PB_W  = biq_pkg::COEFF_W + SAMPLE_BITS + 1;
    localparam int BS_W  = PB_W + 2;
    localparam int PA_W  = biq_pkg::COEFF_W + biq_pkg::HIST_W;
    localparam int ACC_W = ((BS_W + biq_pkg::HIST_FRAC > PA_W) ?
                            BS_W + biq_pkg::HIST_FRAC : PA_W) + 2;
    localparam int V_W   = biq_pkg::HIST_W + 1;
    localparam int TOP_W = ACC_W - biq_pkg::HIST_W + 1;
    localparam int CODE_LSB = biq_pkg::HIST_FRAC;
    localparam int CODE_MSB = biq_pkg::HIST_FRAC + SAMPLE_BITS - 1;

    localparam logic signed [V_W-1:0] OFFSET_Q =
        V_W'(biq_pkg::OFFSET_COUNTS) << biq_pkg::HIST_FRAC;
    localparam logic signed [biq_pkg::HIST_W-1:0] HIST_MAX =
        {1'b0, {(biq_pkg::HIST_W-1){1'b1}}};
    localparam logic signed [biq_pkg::HIST_W-1:0] HIST_MIN =
        {1'b1, {(biq_pkg::HIST_W-1){1'b0}}};

    logic signed [SAMPLE_BITS:0]   x0_s, x1_s, x2_s;
    logic signed [PB_W-1:0]        p_b0, p_b1, p_b2;
    logic signed [PA_W-1:0]        p_a1, p_a2;
    logic signed [BS_W-1:0]        b_sum;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       y_sh;
    logic [TOP_W-1:0]              y_top;
    logic signed [V_W-1:0]         v;

    assign x0_s = signed'({1'b0, i_x0});
    assign x1_s = signed'({1'b0, i_x1});
    assign x2_s = signed'({1'b0, i_x2});

    assign p_b0 = i_coeffs.b0 * x0_s;
    assign p_b1 = i_coeffs.b1 * x1_s;
    assign p_b2 = i_coeffs.b2 * x2_s;
    assign p_a1 = i_coeffs.a1 * i_y1;
    assign p_a2 = i_coeffs.a2 * i_y2;

    // Feed-forward terms carry the coefficient fraction only; lift them to the
    // scale of the feedback terms, which also carry the history fraction.
    assign b_sum = BS_W'(p_b0) + BS_W'(p_b1) + BS_W'(p_b2);
    assign acc   = (ACC_W'(b_sum) <<< biq_pkg::HIST_FRAC) - ACC_W'(p_a1) - ACC_W'(p_a2);

    // Arithmetic shift gives the floor of the exact sum.
    assign y_sh  = acc >>> COEFF_FRAC_BITS;
    assign y_top = y_sh[ACC_W-1:biq_pkg::HIST_W-1];

    always_comb begin
        if ((&y_top) || !(|y_top)) begin
            o_y = y_sh[biq_pkg::HIST_W-1:0];
        end else if (y_sh[ACC_W-1]) begin
            o_y = HIST_MIN;
        end else begin
            o_y = HIST_MAX;
        end
    end

    assign v = V_W'(o_y) + (i_offset_en ? OFFSET_Q : V_W'(0));

    always_comb begin
        if (v[V_W-1]) begin
            o_code = '0;
        end else if (|v[V_W-2:CODE_MSB+1]) begin
            o_code = '1;
        end else begin
            o_code = v[CODE_MSB:CODE_LSB];
        end
    end

endmodule

// ===== sv/biq_checker.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR sample filter: port checker
// Watches the stream ports of the filter unit and flags handshake and flow
// errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "biquad_iir_sample_filter_unit_defines.svh"

module biq_checker #(
    parameter int  SAMPLE_BITS = biq_pkg::DEF_SAMPLE_BITS,
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    `BIQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")
    `BIQ_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result word changed while stalled")

    // With the result register empty nothing can block the input stage.
    `BIQ_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input not ready with empty output")

    // With the input stage known empty, a taken result has no successor.
    `BIQ_ASSERT_NEXT(a_no_extra_word, i_clk, i_rst_n, $past(s_axis_tready && !s_axis_tvalid) && m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "result word without an input word")

endmodule

bind biquad_iir_sample_filter_unit biq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_biq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
